// ----- rtl/core/zsg_pkg.sv -----
package zsg_pkg;

  // Field widths fixed by the request and result formats.
  localparam int CMD_W      = 2;
  localparam int TRACK_W    = 8;
  localparam int VOLUME_W   = 8;
  localparam int COORD_W    = 7;
  localparam int SLOT_NUM_W = 4;
  localparam int ENTRY_W    = 8;
  localparam int DROP_W     = 15;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_READ_RD,
    ST_READ_DATA,
    ST_RESULT
  } state_e;

endpackage

// ----- rtl/core/zone_subscription_grid_unit.sv -----
// Operation: read fetches one cell row; add compares table entries until a match or the table end,
// then read-modify-writes each grid cell of the clipped rectangle; clear zeroes every cell row.
// Throughput: one request at a time; all work is serialized through the single cell-row RAM
// (one read-modify-write per cell) and the source-table RAM (one compare per entry).
// Reset: the table is emptied and a clearing pass zeroes every cell row; in_ready_o stays low
// until it finishes.
module zone_subscription_grid_unit #(
  parameter int GRID_SIDE      = 128,
  parameter int SLOTS_PER_CELL = 10,
  parameter int TABLE_ENTRIES  = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [zsg_pkg::CMD_W-1:0]       command_i,
  input  logic [zsg_pkg::TRACK_W-1:0]     track_number_i,
  input  logic [zsg_pkg::VOLUME_W-1:0]    volume_i,
  input  logic [zsg_pkg::COORD_W-1:0]     min_x_i,
  input  logic [zsg_pkg::COORD_W-1:0]     min_y_i,
  input  logic [zsg_pkg::COORD_W-1:0]     max_x_i,
  input  logic [zsg_pkg::COORD_W-1:0]     max_y_i,
  input  logic [zsg_pkg::SLOT_NUM_W-1:0]  slot_number_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [zsg_pkg::ENTRY_W-1:0]     entry_index_o,
  output logic                            created_o,
  output logic                            table_full_o,
  output logic [zsg_pkg::DROP_W-1:0]      dropped_cells_o,
  output logic                            slot_used_o,
  output logic [zsg_pkg::ENTRY_W-1:0]     slot_entry_o
);

  import zsg_pkg::*;

  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int ADDRW  = $clog2(CELLS);
  localparam int FILLW  = $clog2(SLOTS_PER_CELL + 1);
  localparam int SIW    = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam int TCW    = $clog2(TABLE_ENTRIES + 1);
  localparam int TAW    = $clog2(TABLE_ENTRIES);
  localparam int SRC_W  = TRACK_W + VOLUME_W;

  // One cell row: the slots fill in order, so a fill count marks the used prefix.
  typedef struct packed {
    logic [SLOTS_PER_CELL-1:0][ENTRY_W-1:0] slot;
    logic [FILLW-1:0]                       fill;
  } row_t;

  state_e                 state_q, state_d;
  logic                   clr_cmd_q, clr_cmd_d;
  logic [ADDRW-1:0]       clr_q, clr_d;
  logic [TCW-1:0]         cnt_q, cnt_d;
  logic [TCW-1:0]         k_q, k_d;
  logic [TRACK_W-1:0]     trk_q, trk_d;
  logic [VOLUME_W-1:0]    vol_q, vol_d;
  logic [COORD_W-1:0]     x_q, x_d, y_q, y_d;
  logic [COORD_W-1:0]     y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic                   empty_q, empty_d;
  logic [SLOT_NUM_W-1:0]  slot_q, slot_d;

  // Result under construction.
  logic [ENTRY_W-1:0]     idx_q, idx_d;
  logic                   created_q, created_d;
  logic                   full_q, full_d;
  logic [DROP_W-1:0]      drop_q, drop_d;
  logic                   used_q, used_d;
  logic [ENTRY_W-1:0]     sent_q, sent_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic                   out_load;
  logic [ENTRY_W-1:0]     o_idx_q;
  logic                   o_created_q, o_full_q, o_used_q;
  logic [DROP_W-1:0]      o_drop_q;
  logic [ENTRY_W-1:0]     o_sent_q;

  // Memory ports.
  logic                   tbl_we;
  logic [SRC_W-1:0]       tbl_rdata;
  logic                   cell_we;
  logic [ADDRW-1:0]       cell_waddr, cell_addr;
  row_t                   cell_wdata, cell_rdata, row_upd;

  // Clipped rectangle corners of the incoming request.
  logic [COORD_W-1:0]     mx_clip, my_clip;
  logic                   read_in_grid;

  assign mx_clip = (32'(max_x_i) >= GRID_SIDE) ? COORD_W'(GRID_SIDE - 1) : max_x_i;
  assign my_clip = (32'(max_y_i) >= GRID_SIDE) ? COORD_W'(GRID_SIDE - 1) : max_y_i;
  assign read_in_grid = (32'(min_x_i) < GRID_SIDE) && (32'(min_y_i) < GRID_SIDE)
                        && (32'(slot_number_i) < SLOTS_PER_CELL);

  // Row address of the current cell.
  assign cell_addr = ADDRW'(32'(x_q) * GRID_SIDE + 32'(y_q));

  zsg_ram #(
    .WIDTH (SRC_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (cnt_q[TAW-1:0]),
    .wdata_i ({trk_q, vol_q}),
    .raddr_i (k_q[TAW-1:0]),
    .rdata_o (tbl_rdata)
  );

  zsg_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_wdata),
    .raddr_i (cell_addr),
    .rdata_o (cell_rdata)
  );

  // Row with the current entry appended at the first free slot.
  always_comb begin
    row_upd = cell_rdata;
    row_upd.slot[SIW'(cell_rdata.fill)] = idx_q;
    row_upd.fill = cell_rdata.fill + FILLW'(1);
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_load   = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  // Sequencer: next state and datapath control.
  always_comb begin
    state_d   = state_q;
    clr_cmd_d = clr_cmd_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    trk_d     = trk_q;
    vol_d     = vol_q;
    x_d       = x_q;
    y_d       = y_q;
    y0_d      = y0_q;
    x1_d      = x1_q;
    y1_d      = y1_q;
    empty_d   = empty_q;
    slot_d    = slot_q;
    idx_d     = idx_q;
    created_d = created_q;
    full_d    = full_q;
    drop_d    = drop_q;
    used_d    = used_q;
    sent_d    = sent_q;
    tbl_we     = 1'b0;
    cell_we    = 1'b0;
    cell_waddr = cell_addr;
    cell_wdata = row_upd;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          trk_d     = track_number_i;
          vol_d     = volume_i;
          x_d       = min_x_i;
          y_d       = min_y_i;
          y0_d      = min_y_i;
          x1_d      = mx_clip;
          y1_d      = my_clip;
          empty_d   = (min_x_i > mx_clip) || (min_y_i > my_clip);
          slot_d    = slot_number_i;
          k_d       = '0;
          idx_d     = '0;
          created_d = 1'b0;
          full_d    = 1'b0;
          drop_d    = '0;
          used_d    = 1'b0;
          sent_d    = '0;
          case (cmd_e'(command_i))
            CMD_ADD:   state_d = ST_SEARCH_RD;
            CMD_READ:  state_d = read_in_grid ? ST_READ_RD : ST_RESULT;
            CMD_CLEAR: begin
              cnt_d     = '0;
              clr_d     = '0;
              clr_cmd_d = 1'b1;
              state_d   = ST_CLEAR;
            end
            default:   state_d = ST_RESULT;
          endcase
        end
      end

      // Zero one cell row per cycle.
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_q;
        cell_wdata = '0;
        clr_d      = clr_q + ADDRW'(1);
        if (clr_q == ADDRW'(CELLS - 1)) begin
          clr_d     = '0;
          clr_cmd_d = 1'b0;
          state_d   = clr_cmd_q ? ST_RESULT : ST_IDLE;
        end
      end

      // Table search: the read of entry k is issued here, or the search ends.
      ST_SEARCH_RD: begin
        if (k_q == cnt_q) begin
          if (cnt_q == TCW'(TABLE_ENTRIES)) begin
            full_d  = 1'b1;
            state_d = ST_RESULT;
          end else begin
            tbl_we    = 1'b1;
            idx_d     = ENTRY_W'(cnt_q);
            created_d = 1'b1;
            cnt_d     = cnt_q + TCW'(1);
            state_d   = empty_q ? ST_RESULT : ST_CELL_RD;
          end
        end else begin
          state_d = ST_SEARCH_CMP;
        end
      end

      ST_SEARCH_CMP: begin
        if (tbl_rdata == {trk_q, vol_q}) begin
          idx_d   = ENTRY_W'(k_q);
          state_d = empty_q ? ST_RESULT : ST_CELL_RD;
        end else begin
          k_d     = k_q + TCW'(1);
          state_d = ST_SEARCH_RD;
        end
      end

      ST_CELL_RD: begin
        state_d = ST_CELL_WR;
      end

      // Append to the cell, or count it as dropped, then step through the rectangle.
      ST_CELL_WR: begin
        if (32'(cell_rdata.fill) < SLOTS_PER_CELL) begin
          cell_we = 1'b1;
        end else begin
          drop_d = drop_q + DROP_W'(1);
        end
        state_d = ST_CELL_RD;
        if (y_q == y1_q) begin
          y_d = y0_q;
          if (x_q == x1_q) begin
            state_d = ST_RESULT;
          end else begin
            x_d = x_q + COORD_W'(1);
          end
        end else begin
          y_d = y_q + COORD_W'(1);
        end
      end

      ST_READ_RD: begin
        state_d = ST_READ_DATA;
      end

      ST_READ_DATA: begin
        if (32'(slot_q) < 32'(cell_rdata.fill)) begin
          used_d = 1'b1;
          sent_d = cell_rdata.slot[SIW'(slot_q)];
        end
        state_d = ST_RESULT;
      end

      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cmd_q   <= 1'b0;
      clr_q       <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cmd_q   <= clr_cmd_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    trk_q     <= trk_d;
    vol_q     <= vol_d;
    x_q       <= x_d;
    y_q       <= y_d;
    y0_q      <= y0_d;
    x1_q      <= x1_d;
    y1_q      <= y1_d;
    empty_q   <= empty_d;
    slot_q    <= slot_d;
    idx_q     <= idx_d;
    created_q <= created_d;
    full_q    <= full_d;
    drop_q    <= drop_d;
    used_q    <= used_d;
    sent_q    <= sent_d;
    if (out_load) begin
      o_idx_q     <= idx_q;
      o_created_q <= created_q;
      o_full_q    <= full_q;
      o_drop_q    <= drop_q;
      o_used_q    <= used_q;
      o_sent_q    <= sent_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign entry_index_o   = o_idx_q;
  assign created_o       = o_created_q;
  assign table_full_o    = o_full_q;
  assign dropped_cells_o = o_drop_q;
  assign slot_used_o     = o_used_q;
  assign slot_entry_o    = o_sent_q;

endmodule

// ----- rtl/core/zsg_ram.sv -----
module zsg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
